// ----- sv/stereo_morphing_state_variable_filter_assert.svh -----
// assertion macros used by the filter top level
// no dependencies
`ifndef STEREO_MORPHING_STATE_VARIABLE_FILTER_ASSERT_SVH
`define STEREO_MORPHING_STATE_VARIABLE_FILTER_ASSERT_SVH

// same-cycle implication
`define SMSVF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SMSVF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/smsvf_pkg.sv -----
// types, constants and helper functions of the morphing state-variable filter
// no dependencies
package smsvf_pkg;

    localparam int MUL_AW = 40;
    localparam int MUL_BW = 34;

    typedef logic signed [79:0] t_wide;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SLEW_C, ST_SLEW_M, ST_SQR, ST_FC, ST_DIV, ST_RD0, ST_RD1,
        ST_INTERP, ST_DAMP, ST_LO, ST_HI, ST_BD, ST_MIX, ST_OUT
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                            busy;
        logic                            done;
        logic signed [MUL_AW+MUL_BW-1:0] p;
    } t_mul_rsp;

    localparam logic [1:0]  CFG_CUTOFF   = 2'd0;
    localparam logic [1:0]  CFG_MORPH    = 2'd1;
    localparam logic [31:0] CUT_RESET    = 32'd1932735283;
    localparam logic [33:0] SLEW_Q32     = 34'd6442451;
    localparam logic [45:0] FC_BASE      = 46'd150323855360;
    localparam logic [33:0] FC_GAIN      = 34'd8965;
    localparam logic [30:0] DIV_D        = 31'd1572864000;
    localparam logic [39:0] DAMP_SPAN    = 40'd7214203;
    localparam int          DAMP_BASE    = 19797116;
    localparam int          STATE_LIMIT  = 67108864;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

    // round to nearest, halves away from zero, then shift right
    function automatic t_wide rnd_shift(input t_wide x, input int unsigned s);
        t_wide h;
        h = t_wide'(1) <<< (s - 1);
        return (x + h - (x[79] ? t_wide'(1) : t_wide'(0))) >>> s;
    endfunction

    function automatic logic signed [27:0] clamp_state(input t_wide x);
        if (x > t_wide'(STATE_LIMIT)) begin
            return 28'(STATE_LIMIT);
        end else if (x < -t_wide'(STATE_LIMIT)) begin
            return -28'(STATE_LIMIT);
        end
        return x[27:0];
    endfunction

    // quarter-wave sine entry in q1.30, series to the 15th power
    function automatic logic [30:0] sine_entry(input int unsigned k, input int unsigned lg);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] tmp;
        logic signed [64:0] sum;
        a = (64'(k) * HALF_PI_Q30) >> lg;
        a2 = (a * a + (64'd1 << 29)) >> 30;
        term = a;
        sum = 65'(a);
        for (int n = 1; n <= 7; n++) begin
            tmp = (term * a2) >> 30;
            case (n)
                1: term = tmp / 64'd6;
                2: term = tmp / 64'd20;
                3: term = tmp / 64'd42;
                4: term = tmp / 64'd72;
                5: term = tmp / 64'd110;
                6: term = tmp / 64'd156;
                default: term = tmp / 64'd210;
            endcase
            if (n % 2 == 1) begin
                sum = sum - 65'(term);
            end else begin
                sum = sum + 65'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end else if (sum > 65'sd1073741824) begin
            sum = 65'sd1073741824;
        end
        return sum[30:0];
    endfunction

endpackage

// ----- sv/smsvf_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on smsvf_pkg
module smsvf_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smsvf_pkg::t_mul_req i_req,
    output smsvf_pkg::t_mul_rsp o_rsp
);
    localparam int AW = smsvf_pkg::MUL_AW;
    localparam int BW = smsvf_pkg::MUL_BW;
    localparam int CW = $clog2(BW);

    logic signed [AW:0]   r_acc, n_acc;
    logic        [BW-1:0] r_lo, n_lo;
    logic signed [AW-1:0] r_a, n_a;
    logic        [CW-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    always_comb begin
        logic signed [AW:0] addend;
        logic signed [AW:0] sum;
        logic               last;
        n_acc  = r_acc;
        n_lo   = r_lo;
        n_a    = r_a;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        last   = (r_cnt == CW'(BW - 1));
        addend = '0;
        sum    = '0;
        if (r_busy) begin
            if (r_lo[0]) begin
                addend = last ? -(AW+1)'(r_a) : (AW+1)'(r_a);
            end
            sum   = r_acc + addend;
            n_acc = sum >>> 1;
            n_lo  = {sum[0], r_lo[BW-1:1]};
            n_cnt = r_cnt + CW'(1);
            if (last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_a    = i_req.a;
            n_acc  = '0;
            n_lo   = i_req.b;
            n_cnt  = '0;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_lo  <= n_lo;
        r_a   <= n_a;
    end

    logic [AW+BW:0] w_full;
    assign w_full     = {r_acc, r_lo};
    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.p    = w_full[AW+BW-1:0];

endmodule

// ----- sv/stereo_morphing_state_variable_filter.sv -----
// top level of the stereo morphing state-variable filter
// depends on smsvf_pkg, smsvf_mul and the assertion header
//
// Each accepted frame that is not a clear action runs through a sequencer
// around one shared bit-serial multiplier and a serial divider. A product
// goes through a start step, the shift steps and a done step. A processed
// frame needs fourteen products plus the division and three more steps,
// and the next frame can be taken in the cycle after the result is loaded
// into the output register. A clear action zeroes the filter states and
// gives no result. The output register holds a result while the next
// frame is already being worked on.
`include "stereo_morphing_state_variable_filter_assert.svh"

module stereo_morphing_state_variable_filter #(
    parameter int SAMPLE_BITS        = 24,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);
    localparam int LOG2N = $clog2(SINE_TABLE_ENTRIES);
    localparam int TIX   = LOG2N + 1;
    localparam int NW    = 46 + LOG2N;
    localparam int DCW   = $clog2(NW);
    localparam int unsigned DN_SH = (SAMPLE_BITS < 25) ? 25 - SAMPLE_BITS : 0;
    localparam int unsigned UP_SH = (SAMPLE_BITS > 25) ? SAMPLE_BITS - 25 : 0;

    typedef smsvf_pkg::t_wide t_wide;

    // constant sine table
    logic [30:0] w_sine [0:SINE_TABLE_ENTRIES];
    for (genvar gk = 0; gk <= SINE_TABLE_ENTRIES; gk++) begin : g_sine
        assign w_sine[gk] = smsvf_pkg::sine_entry(gk, LOG2N);
    end

    smsvf_pkg::t_state   r_state, n_state;
    smsvf_pkg::t_mul_req w_mreq;
    smsvf_pkg::t_mul_rsp w_mrsp;

    logic [15:0]             r_cfg_cut, n_cfg_cut, r_cfg_mor, n_cfg_mor;
    logic [31:0]             r_cut, n_cut, r_mor, n_mor;
    logic signed [27:0]      r_low [0:1];
    logic signed [27:0]      r_band [0:1];
    logic signed [27:0]      n_low [0:1];
    logic signed [27:0]      n_band [0:1];
    logic signed [26:0]      r_x [0:1];
    logic signed [26:0]      n_x [0:1];
    logic                    r_wait, n_wait, r_ch, n_ch;
    logic [31:0]             r_c2, n_c2, r_f, n_f;
    logic [45:0]             r_fc, n_fc;
    logic [NW-1:0]           r_num, n_num;
    logic [30:0]             r_rem, n_rem;
    logic [DCW-1:0]          r_dcnt, n_dcnt;
    logic [TIX-1:0]          r_idx, n_idx, w_tix;
    logic [15:0]             r_frac, n_frac;
    logic [30:0]             r_s0, n_s0;
    logic signed [25:0]      r_damp, n_damp;
    logic [16:0]             r_t, n_t;
    logic                    r_upper, n_upper;
    logic signed [27:0]      r_lo, n_lo, r_hi, n_hi, r_bd, n_bd;
    logic [SAMPLE_BITS-1:0]  r_y0, n_y0;
    logic                    r_ov, n_ov;
    logic [SAMPLE_BITS-1:0]  r_ol, n_ol, r_or, n_or;
    logic                    w_in_acc;
    logic [30:0]             w_rd;

    assign o_in_stall = (r_state != smsvf_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_tix      = (r_state == smsvf_pkg::ST_INTERP) ? r_idx + TIX'(1) : r_idx;
    assign w_rd       = w_sine[w_tix];

    smsvf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    function automatic t_wide to_q24(input logic signed [SAMPLE_BITS-1:0] s);
        if (SAMPLE_BITS <= 25) begin
            return t_wide'(s) <<< DN_SH;
        end
        return smsvf_pkg::rnd_shift(t_wide'(s), UP_SH);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] to_sample(input t_wide y);
        t_wide r;
        t_wide lim;
        if (SAMPLE_BITS < 25) begin
            r = smsvf_pkg::rnd_shift(y, DN_SH);
        end else begin
            r = y <<< UP_SH;
        end
        lim = t_wide'(1) <<< (SAMPLE_BITS - 1);
        if (r > lim - t_wide'(1)) begin
            r = lim - t_wide'(1);
        end else if (r < -lim) begin
            r = -lim;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    always_comb begin
        t_wide p, tmp, ad;
        logic [31:0] ge_trial;
        logic        ge;
        logic [15:0] v16;
        n_state   = r_state;
        n_cfg_cut = r_cfg_cut;
        n_cfg_mor = r_cfg_mor;
        n_cut     = r_cut;
        n_mor     = r_mor;
        n_low     = r_low;
        n_band    = r_band;
        n_x       = r_x;
        n_wait    = r_wait;
        n_ch      = r_ch;
        n_c2      = r_c2;
        n_f       = r_f;
        n_fc      = r_fc;
        n_num     = r_num;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_idx     = r_idx;
        n_frac    = r_frac;
        n_s0      = r_s0;
        n_damp    = r_damp;
        n_t       = r_t;
        n_upper   = r_upper;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_bd      = r_bd;
        n_y0      = r_y0;
        n_ov      = r_ov;
        n_ol      = r_ol;
        n_or      = r_or;
        w_mreq    = '0;
        p         = t_wide'(w_mrsp.p);
        tmp       = '0;
        ad        = '0;
        ge_trial  = '0;
        ge        = 1'b0;
        v16       = r_mor[31:16];

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                smsvf_pkg::CFG_CUTOFF: n_cfg_cut = i_cfg_data;
                smsvf_pkg::CFG_MORPH:  n_cfg_mor = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            smsvf_pkg::ST_SLEW_C: begin
                tmp = t_wide'({1'b0, r_cfg_cut, 16'd0}) - t_wide'({1'b0, r_cut});
                w_mreq.a = tmp[smsvf_pkg::MUL_AW-1:0];
                w_mreq.b = smsvf_pkg::SLEW_Q32;
            end
            smsvf_pkg::ST_SLEW_M: begin
                tmp = t_wide'({1'b0, r_cfg_mor, 16'd0}) - t_wide'({1'b0, r_mor});
                w_mreq.a = tmp[smsvf_pkg::MUL_AW-1:0];
                w_mreq.b = smsvf_pkg::SLEW_Q32;
            end
            smsvf_pkg::ST_SQR: begin
                w_mreq.a = {24'd0, r_cut[31:16]};
                w_mreq.b = {18'd0, r_cut[31:16]};
            end
            smsvf_pkg::ST_FC: begin
                w_mreq.a = {8'd0, r_c2};
                w_mreq.b = smsvf_pkg::FC_GAIN;
            end
            smsvf_pkg::ST_INTERP: begin
                tmp = t_wide'({1'b0, w_rd}) - t_wide'({1'b0, r_s0});
                w_mreq.a = tmp[smsvf_pkg::MUL_AW-1:0];
                w_mreq.b = {18'd0, r_frac};
            end
            smsvf_pkg::ST_DAMP: begin
                tmp = t_wide'({1'b0, v16, 1'b0}) - t_wide'(65536);
                if (tmp[79]) begin
                    tmp = -tmp;
                end
                tmp = t_wide'(65536) - tmp;
                w_mreq.a = smsvf_pkg::DAMP_SPAN;
                w_mreq.b = {17'd0, tmp[16:0]};
            end
            smsvf_pkg::ST_LO: begin
                w_mreq.a = {8'd0, r_f};
                w_mreq.b = 34'(r_band[r_ch]);
            end
            smsvf_pkg::ST_HI: begin
                w_mreq.a = 40'(r_damp);
                w_mreq.b = 34'(r_band[r_ch]);
            end
            smsvf_pkg::ST_BD: begin
                w_mreq.a = {8'd0, r_f};
                w_mreq.b = 34'(r_hi);
            end
            smsvf_pkg::ST_MIX: begin
                tmp = r_upper ? t_wide'(r_hi) - t_wide'(r_bd) : t_wide'(r_bd) - t_wide'(r_lo);
                w_mreq.a = tmp[smsvf_pkg::MUL_AW-1:0];
                w_mreq.b = {17'd0, r_t};
            end
            default: ;
        endcase

        case (r_state)
            smsvf_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_action) begin
                        n_low[0]  = '0;
                        n_low[1]  = '0;
                        n_band[0] = '0;
                        n_band[1] = '0;
                    end else begin
                        tmp    = to_q24(i_left_in);
                        n_x[0] = tmp[26:0];
                        tmp    = to_q24(i_right_in);
                        n_x[1] = tmp[26:0];
                        n_ch   = 1'b0;
                        n_state = smsvf_pkg::ST_SLEW_C;
                    end
                end
            end
            smsvf_pkg::ST_DIV: begin
                ge_trial = {r_rem, r_num[NW-1]};
                ge       = (ge_trial >= {1'b0, smsvf_pkg::DIV_D});
                tmp      = ge ? t_wide'({1'b0, ge_trial}) - t_wide'({1'b0, smsvf_pkg::DIV_D})
                              : t_wide'({1'b0, ge_trial});
                n_rem    = tmp[30:0];
                n_num    = {r_num[NW-2:0], ge};
                n_dcnt   = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(NW - 1)) begin
                    n_state = smsvf_pkg::ST_RD0;
                end
            end
            smsvf_pkg::ST_RD0: begin
                if (r_num[NW-1:16] >= (NW-16)'(SINE_TABLE_ENTRIES)) begin
                    n_idx  = TIX'(SINE_TABLE_ENTRIES - 1);
                    n_frac = 16'hffff;
                end else begin
                    n_idx  = {1'b0, r_num[LOG2N+15:16]};
                    n_frac = r_num[15:0];
                end
                n_state = smsvf_pkg::ST_RD1;
            end
            smsvf_pkg::ST_RD1: begin
                n_s0    = w_rd;
                n_state = smsvf_pkg::ST_INTERP;
            end
            smsvf_pkg::ST_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_ol    = r_y0;
                    n_or    = to_sample(t_wide'(r_lo));
                    n_state = smsvf_pkg::ST_IDLE;
                end
            end
            default: begin
                if (!r_wait) begin
                    w_mreq.start = 1'b1;
                    n_wait       = 1'b1;
                end else if (w_mrsp.done) begin
                    n_wait = 1'b0;
                    case (r_state)
                        smsvf_pkg::ST_SLEW_C: begin
                            tmp     = t_wide'({1'b0, r_cut}) + smsvf_pkg::rnd_shift(p, 32);
                            n_cut   = tmp[31:0];
                            n_state = smsvf_pkg::ST_SLEW_M;
                        end
                        smsvf_pkg::ST_SLEW_M: begin
                            tmp     = t_wide'({1'b0, r_mor}) + smsvf_pkg::rnd_shift(p, 32);
                            n_mor   = tmp[31:0];
                            n_state = smsvf_pkg::ST_SQR;
                        end
                        smsvf_pkg::ST_SQR: begin
                            n_c2    = p[31:0];
                            n_state = smsvf_pkg::ST_FC;
                        end
                        smsvf_pkg::ST_FC: begin
                            n_fc    = smsvf_pkg::FC_BASE + p[45:0];
                            n_num   = {n_fc, {LOG2N{1'b0}}};
                            n_rem   = '0;
                            n_dcnt  = '0;
                            n_state = smsvf_pkg::ST_DIV;
                        end
                        smsvf_pkg::ST_INTERP: begin
                            tmp     = t_wide'({1'b0, r_s0}) + ((p + t_wide'(32768)) >>> 16);
                            n_f     = {tmp[30:0], 1'b0};
                            n_state = smsvf_pkg::ST_DAMP;
                        end
                        smsvf_pkg::ST_DAMP: begin
                            tmp     = t_wide'(smsvf_pkg::DAMP_BASE) - smsvf_pkg::rnd_shift(p, 16);
                            n_damp  = tmp[25:0];
                            n_upper = v16[15];
                            n_t     = v16[15] ? {1'b0, v16[14:0], 1'b0} : {v16, 1'b0};
                            n_state = smsvf_pkg::ST_LO;
                        end
                        smsvf_pkg::ST_LO: begin
                            n_lo = smsvf_pkg::clamp_state(t_wide'(r_low[r_ch])
                                                          + smsvf_pkg::rnd_shift(p, 30));
                            n_state = smsvf_pkg::ST_HI;
                        end
                        smsvf_pkg::ST_HI: begin
                            n_hi = smsvf_pkg::clamp_state(t_wide'(r_x[r_ch]) - t_wide'(r_lo)
                                                          - smsvf_pkg::rnd_shift(p, 24));
                            n_state = smsvf_pkg::ST_BD;
                        end
                        smsvf_pkg::ST_BD: begin
                            n_bd = smsvf_pkg::clamp_state(t_wide'(r_band[r_ch])
                                                          + smsvf_pkg::rnd_shift(p, 30));
                            n_low[r_ch]  = r_lo;
                            n_band[r_ch] = n_bd;
                            n_state = smsvf_pkg::ST_MIX;
                        end
                        smsvf_pkg::ST_MIX: begin
                            ad = (r_upper ? t_wide'(r_bd) : t_wide'(r_lo))
                                 + smsvf_pkg::rnd_shift(p, 16);
                            if (!r_ch) begin
                                n_y0    = to_sample(ad);
                                n_ch    = 1'b1;
                                n_state = smsvf_pkg::ST_LO;
                            end else begin
                                // right result parks in the low temporary
                                n_lo    = ad[27:0];
                                n_state = smsvf_pkg::ST_OUT;
                            end
                        end
                        default: n_state = smsvf_pkg::ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= smsvf_pkg::ST_IDLE;
            r_cfg_cut <= 16'd29491;
            r_cfg_mor <= '0;
            r_cut     <= smsvf_pkg::CUT_RESET;
            r_mor     <= '0;
            r_low[0]  <= '0;
            r_low[1]  <= '0;
            r_band[0] <= '0;
            r_band[1] <= '0;
            r_wait    <= 1'b0;
            r_ch      <= 1'b0;
            r_dcnt    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cfg_cut <= n_cfg_cut;
            r_cfg_mor <= n_cfg_mor;
            r_cut     <= n_cut;
            r_mor     <= n_mor;
            r_low     <= n_low;
            r_band    <= n_band;
            r_wait    <= n_wait;
            r_ch      <= n_ch;
            r_dcnt    <= n_dcnt;
            r_ov      <= n_ov;
        end
        r_x     <= n_x;
        r_c2    <= n_c2;
        r_f     <= n_f;
        r_fc    <= n_fc;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_idx   <= n_idx;
        r_frac  <= n_frac;
        r_s0    <= n_s0;
        r_damp  <= n_damp;
        r_t     <= n_t;
        r_upper <= n_upper;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_bd    <= n_bd;
        r_y0    <= n_y0;
        r_ol    <= n_ol;
        r_or    <= n_or;
    end

    assign o_out_valid = r_ov;
    assign o_left_out  = r_ol;
    assign o_right_out = r_or;

    `SMSVF_ASSERT_IMPLY(a_mul_start_idle, i_clk, i_rst_n, w_mreq.start, !w_mrsp.busy)
    `SMSVF_ASSERT_IMPLY(a_load_from_out, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == smsvf_pkg::ST_OUT)
    `SMSVF_ASSERT_NEXT(a_clear_no_slew, i_clk, i_rst_n, w_in_acc && i_action, r_cut == $past(r_cut))
    `SMSVF_ASSERT_IMPLY(a_rem_bound, i_clk, i_rst_n, r_state == smsvf_pkg::ST_RD0, r_rem < smsvf_pkg::DIV_D)

endmodule
